>>> rtl/bsv_pkg.sv
// bsv_pkg: shared types, codes and constants for the bencode stream validator
// no dependencies

package bsv_pkg;

  localparam int MAX_DEPTH_DEF   = 32;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int VAL_W           = 63;
  localparam int DEPTH_OUT_W     = 6;
  localparam int OFFSET_OUT_W    = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    MODE_EXPECT = 3'd0,
    MODE_LEN    = 3'd1,
    MODE_BODY   = 3'd2,
    MODE_INT    = 3'd3,
    MODE_DONE   = 3'd4,
    MODE_HALT   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_SYNTAX   = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_TRAIL    = 3'd4,
    ST_DEPTH    = 3'd5,
    ST_OVER     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STR_HDR  = 3'd1,
    EV_STR_END  = 3'd2,
    EV_INT_END  = 3'd3,
    EV_LIST     = 3'd4,
    EV_DICT     = 3'd5,
    EV_CLOSE    = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LIST = 2'd1,
    KIND_DKEY = 2'd2,
    KIND_DVAL = 2'd3
  } kind_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       is_e;
    logic       is_i;
    logic       is_l;
    logic       is_d;
    logic       is_colon;
    logic       last;
  } cls_t;

endpackage

>>> rtl/bsv_front.sv
// bsv_front: input stage that accepts beats, classifies each byte and queues it for the back
// depends on bsv_pkg

module bsv_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  output logic          q_valid,
  input  logic          q_stall,
  output bsv_pkg::cls_t q_cls
);

  localparam int QD = bsv_pkg::QUEUE_DEPTH;
  localparam int QA = $clog2(QD);

  bsv_pkg::cls_t mem_r [QD];
  logic [QA-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QA:0]   cnt_r, cnt_nxt;
  bsv_pkg::cls_t cls;
  logic          push, pop;

  always_comb begin
    cls          = '0;
    cls.is_digit = (in_data_byte >= bsv_pkg::CH_ZERO) && (in_data_byte <= bsv_pkg::CH_NINE);
    cls.digit    = cls.is_digit ? 4'(in_data_byte - bsv_pkg::CH_ZERO) : 4'd0;
    cls.is_e     = in_data_byte == bsv_pkg::CH_E;
    cls.is_i     = in_data_byte == bsv_pkg::CH_I;
    cls.is_l     = in_data_byte == bsv_pkg::CH_L;
    cls.is_d     = in_data_byte == bsv_pkg::CH_D;
    cls.is_colon = in_data_byte == bsv_pkg::CH_COLON;
    cls.last     = in_last_byte;
  end

  assign in_stall = (cnt_r == (QA+1)'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && !q_stall;
  assign q_cls    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == QA'(QD-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? ((rp_r == QA'(QD-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (QA+1)'(push) - (QA+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

>>> rtl/bsv_back.sv
// bsv_back: parse state machine with container stack and result register
// depends on bsv_pkg

module bsv_back #(
  parameter int MAX_DEPTH   = bsv_pkg::MAX_DEPTH_DEF,
  parameter int OFFSET_BITS = bsv_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_dict,
  input  logic          q_valid,
  output logic          q_stall,
  input  bsv_pkg::cls_t q_cls,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    out_status,
  output logic [2:0]    out_event_res,
  output logic [62:0]   out_token_value,
  output logic [5:0]    out_nest_depth,
  output logic [31:0]   out_byte_offset,
  output logic          out_buffer_end
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int SA = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int VW = bsv_pkg::VAL_W;
  localparam logic [VW-1:0] VAL_MAX = '1;
  // largest accumulator that may take another digit d is (max-d)/10
  localparam logic [VW-1:0] LIM_HI = VW'(VAL_MAX / 10);

  bsv_pkg::mode_t   mode_r, mode_nxt;
  bsv_pkg::status_t sticky_r, sticky_nxt;
  logic [VW-1:0]    len_r, len_nxt, int_r, int_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [OFFSET_BITS-1:0] pos_r;
  bsv_pkg::kind_t   stack_r [MAX_DEPTH];
  logic             stk_we;
  logic [SA-1:0]    stk_wa;
  bsv_pkg::kind_t   stk_wd;

  logic             fire, ovld_r;
  bsv_pkg::kind_t   top;
  logic [SA-1:0]    top_idx;
  bsv_pkg::event_t  ev;
  logic [VW-1:0]    tok;
  bsv_pkg::status_t st_out;
  logic [VW-1:0]    acc_sel, acc_add;
  logic             acc_ok;

  logic [2:0]  o_status_r, o_event_r;
  logic [62:0] o_tok_r;
  logic [5:0]  o_depth_r;
  logic [31:0] o_off_r;
  logic        o_end_r;

  assign q_stall = ovld_r && out_stall;
  assign fire    = q_valid && !q_stall;

  assign top_idx = SA'(depth_r - 1'b1);
  assign top     = (depth_r != '0) ? stack_r[top_idx] : bsv_pkg::KIND_NONE;

  // digit accumulate: overflow check against VAL_MAX / 10 and a multiply-by-ten add
  always_comb begin
    acc_sel = (mode_r == bsv_pkg::MODE_INT) ? int_r : len_r;
    acc_ok  = (acc_sel < LIM_HI) ||
              ((acc_sel == LIM_HI) && (q_cls.digit <= 4'(VAL_MAX % 10)));
    acc_add = VW'({acc_sel, 3'b000}) + VW'({acc_sel, 1'b0}) + VW'(q_cls.digit);
  end

  always_comb begin
    mode_nxt   = mode_r;
    sticky_nxt = sticky_r;
    len_nxt    = len_r;
    int_nxt    = int_r;
    depth_nxt  = depth_r;
    stk_we     = 1'b0;
    stk_wa     = top_idx;
    stk_wd     = bsv_pkg::KIND_NONE;
    ev         = bsv_pkg::EV_NONE;
    tok        = '0;
    begin : finish_blk
      logic fin;
      logic [DW-1:0] fdepth;
      fin    = 1'b0;
      fdepth = depth_r;
      unique case (mode_r)
        bsv_pkg::MODE_EXPECT: begin
          if (q_cls.is_e) begin
            if (top == bsv_pkg::KIND_LIST || top == bsv_pkg::KIND_DKEY) begin
              depth_nxt = depth_r - 1'b1;
              fdepth    = depth_r - 1'b1;
              ev        = bsv_pkg::EV_CLOSE;
              fin       = 1'b1;
            end else begin
              sticky_nxt = bsv_pkg::ST_SYNTAX;
              mode_nxt   = bsv_pkg::MODE_HALT;
            end
          end else if (depth_r == '0 && req_dict && !q_cls.is_d) begin
            sticky_nxt = bsv_pkg::ST_SYNTAX;
            mode_nxt   = bsv_pkg::MODE_HALT;
          end else if (q_cls.is_digit) begin
            len_nxt  = VW'(q_cls.digit);
            mode_nxt = bsv_pkg::MODE_LEN;
          end else if (top == bsv_pkg::KIND_DKEY) begin
            sticky_nxt = bsv_pkg::ST_SYNTAX;
            mode_nxt   = bsv_pkg::MODE_HALT;
          end else if (q_cls.is_i) begin
            int_nxt  = '0;
            mode_nxt = bsv_pkg::MODE_INT;
          end else if (q_cls.is_l || q_cls.is_d) begin
            if (depth_r >= DW'(MAX_DEPTH)) begin
              sticky_nxt = bsv_pkg::ST_DEPTH;
              mode_nxt   = bsv_pkg::MODE_HALT;
            end else begin
              stk_we    = 1'b1;
              stk_wa    = SA'(depth_r);
              stk_wd    = q_cls.is_l ? bsv_pkg::KIND_LIST : bsv_pkg::KIND_DKEY;
              depth_nxt = depth_r + 1'b1;
              ev        = q_cls.is_l ? bsv_pkg::EV_LIST : bsv_pkg::EV_DICT;
            end
          end else begin
            sticky_nxt = bsv_pkg::ST_SYNTAX;
            mode_nxt   = bsv_pkg::MODE_HALT;
          end
        end
        bsv_pkg::MODE_LEN: begin
          if (q_cls.is_digit) begin
            if (acc_ok) begin
              len_nxt = acc_add;
            end else begin
              sticky_nxt = bsv_pkg::ST_OVER;
              mode_nxt   = bsv_pkg::MODE_HALT;
            end
          end else if (q_cls.is_colon) begin
            ev  = bsv_pkg::EV_STR_HDR;
            tok = len_r;
            if (len_r == '0) begin
              fin = 1'b1;
            end else begin
              mode_nxt = bsv_pkg::MODE_BODY;
            end
          end else begin
            sticky_nxt = bsv_pkg::ST_SYNTAX;
            mode_nxt   = bsv_pkg::MODE_HALT;
          end
        end
        bsv_pkg::MODE_BODY: begin
          len_nxt = (len_r != '0) ? len_r - 1'b1 : len_r;
          if (len_r <= VW'(1)) begin
            ev  = bsv_pkg::EV_STR_END;
            fin = 1'b1;
          end
        end
        bsv_pkg::MODE_INT: begin
          if (q_cls.is_digit) begin
            if (acc_ok) begin
              int_nxt = acc_add;
            end else begin
              sticky_nxt = bsv_pkg::ST_OVER;
              mode_nxt   = bsv_pkg::MODE_HALT;
            end
          end else if (q_cls.is_e) begin
            ev  = bsv_pkg::EV_INT_END;
            tok = int_r;
            fin = 1'b1;
          end else begin
            sticky_nxt = bsv_pkg::ST_SYNTAX;
            mode_nxt   = bsv_pkg::MODE_HALT;
          end
        end
        bsv_pkg::MODE_DONE: begin
          sticky_nxt = bsv_pkg::ST_TRAIL;
          mode_nxt   = bsv_pkg::MODE_HALT;
        end
        default: begin
        end
      endcase
      // value finished: flip dictionary phase or complete at top level
      if (fin) begin
        if (fdepth == '0) begin
          mode_nxt   = bsv_pkg::MODE_DONE;
          sticky_nxt = bsv_pkg::ST_COMPLETE;
        end else begin
          mode_nxt = bsv_pkg::MODE_EXPECT;
          stk_wa   = SA'(fdepth - 1'b1);
          if (stack_r[SA'(fdepth - 1'b1)] == bsv_pkg::KIND_DKEY) begin
            stk_we = 1'b1;
            stk_wd = bsv_pkg::KIND_DVAL;
          end else if (stack_r[SA'(fdepth - 1'b1)] == bsv_pkg::KIND_DVAL) begin
            stk_we = 1'b1;
            stk_wd = bsv_pkg::KIND_DKEY;
          end
        end
      end
    end
    st_out = (q_cls.last && sticky_nxt == bsv_pkg::ST_RUN) ? bsv_pkg::ST_TRUNC : sticky_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bsv_pkg::MODE_EXPECT;
      sticky_r <= bsv_pkg::ST_RUN;
      len_r    <= '0;
      int_r    <= '0;
      depth_r  <= '0;
      pos_r    <= '0;
      ovld_r   <= 1'b0;
    end else begin
      if (fire) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
      if (fire) begin
        if (q_cls.last) begin
          mode_r   <= bsv_pkg::MODE_EXPECT;
          sticky_r <= bsv_pkg::ST_RUN;
          len_r    <= '0;
          int_r    <= '0;
          depth_r  <= '0;
          pos_r    <= '0;
        end else begin
          mode_r   <= mode_nxt;
          sticky_r <= sticky_nxt;
          len_r    <= len_nxt;
          int_r    <= int_nxt;
          depth_r  <= depth_nxt;
          pos_r    <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stk_we) begin
      stack_r[stk_wa] <= stk_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_status_r <= st_out;
      o_event_r  <= ev;
      o_tok_r    <= tok;
      o_depth_r  <= 6'(depth_nxt);
      o_off_r    <= 32'(pos_r);
      o_end_r    <= q_cls.last;
    end
  end

  assign out_valid       = ovld_r;
  assign out_status      = o_status_r;
  assign out_event_res   = o_event_r;
  assign out_token_value = o_tok_r;
  assign out_nest_depth  = o_depth_r;
  assign out_byte_offset = o_off_r;
  assign out_buffer_end  = o_end_r;

endmodule

>>> rtl/bencode_stream_validator.sv
// bencode_stream_validator: top level joining the classify front and parse back
// depends on bsv_pkg, bsv_front, bsv_back
//
// usage: feed one byte of a bencoded buffer per beat on in_data_byte, with
// in_last_byte high on the buffer's final byte. every input beat yields
// exactly one result beat: status, token event, string length or integer
// value, open container count, byte offset and the last-byte echo.
// throughput is one byte per cycle while the receiver does not hold out_stall;
// the parse state update, digit accumulate (multiply by ten and add) included,
// is combinational between registers. a result beat passes through the
// two-entry classify queue and then the output register.
// in_stall rises only when the queue is full, which happens when the
// receiver holds out_stall; results are then held unchanged.
// cfg_require_dictionary is written whenever cfg_we is high; change it only
// between buffers. reset (rst_n low, synchronous) clears the parse state,
// empties the queue and sets require_dictionary to 1. no clearing pass is
// needed; the container stack is only read below the open depth.

module bencode_stream_validator #(
  parameter int MAX_DEPTH   = bsv_pkg::MAX_DEPTH_DEF,
  parameter int OFFSET_BITS = bsv_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_require_dictionary,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_event_res,
  output logic [62:0] out_token_value,
  output logic [5:0]  out_nest_depth,
  output logic [31:0] out_byte_offset,
  output logic        out_buffer_end
);

  logic          req_dict_r;
  logic          q_valid, q_stall;
  bsv_pkg::cls_t q_cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_dict_r <= 1'b1;
    end else if (cfg_we) begin
      req_dict_r <= cfg_require_dictionary;
    end
  end

  bsv_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_last_byte,
    .q_valid, .q_stall, .q_cls
  );

  bsv_back #(.MAX_DEPTH(MAX_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk, .rst_n, .req_dict(req_dict_r), .q_valid, .q_stall, .q_cls,
    .out_valid, .out_stall, .out_status, .out_event_res, .out_token_value,
    .out_nest_depth, .out_byte_offset, .out_buffer_end
  );

endmodule

>>> rtl/bsv_checker.sv
// bsv_checker: port-level assertions for bencode_stream_validator, bound to the top
// depends on bsv_pkg and the top level's ports

module bsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [2:0]  out_event_res,
  input logic [62:0] out_token_value,
  input logic [5:0]  out_nest_depth
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_value))
    else $error("result changed while stalled");

  a_tok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != bsv_pkg::EV_STR_HDR &&
    out_event_res != bsv_pkg::EV_INT_END |-> out_token_value == '0)
    else $error("token value without a value event");

  a_err_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bsv_pkg::ST_TRAIL || out_status == bsv_pkg::ST_DEPTH)
    |-> out_event_res == bsv_pkg::EV_NONE)
    else $error("event on an error beat");

  a_complete_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bsv_pkg::ST_COMPLETE && out_event_res != bsv_pkg::EV_NONE
    |-> out_nest_depth == '0)
    else $error("completion with open containers");

endmodule

bind bencode_stream_validator bsv_checker u_bsv_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_status, .out_event_res,
  .out_token_value, .out_nest_depth
);

>>> verif/tb.sv
// tb: self-checking testbench for bencode_stream_validator
// drives bencoded buffers byte by byte and checks every result beat against
// a local parse predictor; depends on bsv_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH_LIMIT = bsv_pkg::MAX_DEPTH_DEF;
  localparam int IDLE_LIMIT  = 3000;
  localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_require_dictionary = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_event_res;
  logic [62:0] out_token_value;
  logic [5:0]  out_nest_depth;
  logic [31:0] out_byte_offset;
  logic        out_buffer_end;

  bencode_stream_validator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_require_dictionary(cfg_require_dictionary),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_event_res(out_event_res),
    .out_token_value(out_token_value), .out_nest_depth(out_nest_depth),
    .out_byte_offset(out_byte_offset), .out_buffer_end(out_buffer_end)
  );

  always #4 clk = ~clk;

  typedef struct {
    bsv_pkg::status_t st;
    bsv_pkg::event_t  ev;
    logic [62:0]      tok;
    logic [5:0]       dep;
    logic [31:0]      off;
    logic             bend;
  } parse_res_t;

  typedef struct {
    logic [7:0]       b;
    logic             last;
    bit               typed;
    bsv_pkg::status_t st;
    bsv_pkg::event_t  ev;
    logic [62:0]      tok;
  } dir_row_t;

  parse_res_t pending_results[$];
  logic [7:0] buf_bytes[$];
  int         mismatches = 0;
  int         idle_cycles = 0;

  // predictor state
  bit               req_dict;
  bsv_pkg::mode_t   p_mode;
  logic [63:0]      len_acc;
  logic [63:0]      int_acc;
  int               open_cnt;
  bsv_pkg::kind_t   kinds[DEPTH_LIMIT];
  logic [31:0]      pos;
  bsv_pkg::status_t sticky;

  function automatic void clear_parse();
    p_mode = bsv_pkg::MODE_EXPECT;
    len_acc = '0;
    int_acc = '0;
    open_cnt = 0;
    pos = '0;
    sticky = bsv_pkg::ST_RUN;
  endfunction

  function automatic void halt(bsv_pkg::status_t code);
    sticky = code;
    p_mode = bsv_pkg::MODE_HALT;
  endfunction

  function automatic void value_done();
    if (open_cnt == 0) begin
      p_mode = bsv_pkg::MODE_DONE;
      sticky = bsv_pkg::ST_COMPLETE;
    end else begin
      if (kinds[open_cnt-1] == bsv_pkg::KIND_DKEY) kinds[open_cnt-1] = bsv_pkg::KIND_DVAL;
      else if (kinds[open_cnt-1] == bsv_pkg::KIND_DVAL) kinds[open_cnt-1] = bsv_pkg::KIND_DKEY;
      p_mode = bsv_pkg::MODE_EXPECT;
    end
  endfunction

  function automatic parse_res_t parse_byte(logic [7:0] b, logic last);
    parse_res_t r;
    bit dig;
    logic [63:0] d;
    bsv_pkg::kind_t top;
    r.ev = bsv_pkg::EV_NONE;
    r.tok = '0;
    r.off = pos;
    r.bend = last;
    dig = (b >= bsv_pkg::CH_ZERO) && (b <= bsv_pkg::CH_NINE);
    d = dig ? 64'(b - bsv_pkg::CH_ZERO) : 64'd0;
    case (p_mode)
      bsv_pkg::MODE_EXPECT: begin
        top = (open_cnt != 0) ? kinds[open_cnt-1] : bsv_pkg::KIND_NONE;
        if (b == bsv_pkg::CH_E) begin
          if (top == bsv_pkg::KIND_LIST || top == bsv_pkg::KIND_DKEY) begin
            open_cnt--;
            r.ev = bsv_pkg::EV_CLOSE;
            value_done();
          end else halt(bsv_pkg::ST_SYNTAX);
        end else if (open_cnt == 0 && req_dict && b != bsv_pkg::CH_D) begin
          halt(bsv_pkg::ST_SYNTAX);
        end else if (dig) begin
          len_acc = d;
          p_mode = bsv_pkg::MODE_LEN;
        end else if (top == bsv_pkg::KIND_DKEY) begin
          halt(bsv_pkg::ST_SYNTAX);
        end else if (b == bsv_pkg::CH_I) begin
          int_acc = '0;
          p_mode = bsv_pkg::MODE_INT;
        end else if (b == bsv_pkg::CH_L || b == bsv_pkg::CH_D) begin
          if (open_cnt >= DEPTH_LIMIT) halt(bsv_pkg::ST_DEPTH);
          else begin
            kinds[open_cnt] = (b == bsv_pkg::CH_L) ? bsv_pkg::KIND_LIST : bsv_pkg::KIND_DKEY;
            open_cnt++;
            r.ev = (b == bsv_pkg::CH_L) ? bsv_pkg::EV_LIST : bsv_pkg::EV_DICT;
          end
        end else halt(bsv_pkg::ST_SYNTAX);
      end
      bsv_pkg::MODE_LEN: begin
        if (dig) begin
          if (len_acc > (VMAX - d) / 10) halt(bsv_pkg::ST_OVER);
          else len_acc = len_acc * 10 + d;
        end else if (b == bsv_pkg::CH_COLON) begin
          r.ev = bsv_pkg::EV_STR_HDR;
          r.tok = len_acc[62:0];
          if (len_acc == 0) value_done();
          else p_mode = bsv_pkg::MODE_BODY;
        end else halt(bsv_pkg::ST_SYNTAX);
      end
      bsv_pkg::MODE_BODY: begin
        if (len_acc > 0) len_acc--;
        if (len_acc == 0) begin
          r.ev = bsv_pkg::EV_STR_END;
          value_done();
        end
      end
      bsv_pkg::MODE_INT: begin
        if (dig) begin
          if (int_acc > (VMAX - d) / 10) halt(bsv_pkg::ST_OVER);
          else int_acc = int_acc * 10 + d;
        end else if (b == bsv_pkg::CH_E) begin
          r.ev = bsv_pkg::EV_INT_END;
          r.tok = int_acc[62:0];
          value_done();
        end else halt(bsv_pkg::ST_SYNTAX);
      end
      bsv_pkg::MODE_DONE: halt(bsv_pkg::ST_TRAIL);
      default: ;
    endcase
    r.st = (last && sticky == bsv_pkg::ST_RUN) ? bsv_pkg::ST_TRUNC : sticky;
    r.dep = 6'(open_cnt);
    pos = pos + 1;
    if (last) clear_parse();
    return r;
  endfunction

  // directed rows, walked from reset with require_dictionary = 1
  dir_row_t directed_rows [0:24] = '{
    '{bsv_pkg::CH_D,     1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_DICT,    63'd0},
    '{bsv_pkg::CH_ZERO,  1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_COLON, 1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_STR_HDR, 63'd0},
    '{bsv_pkg::CH_I,     1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_E,     1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_INT_END, 63'd0},
    '{bsv_pkg::CH_E,     1'b0, 1'b1, bsv_pkg::ST_COMPLETE, bsv_pkg::EV_CLOSE,   63'd0},
    '{bsv_pkg::CH_E,     1'b1, 1'b1, bsv_pkg::ST_TRAIL,    bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_L,     1'b1, 1'b1, bsv_pkg::ST_SYNTAX,   bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_D,     1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_DICT,    63'd0},
    '{bsv_pkg::CH_I,     1'b0, 1'b1, bsv_pkg::ST_SYNTAX,   bsv_pkg::EV_NONE,    63'd0},
    '{8'hFF,             1'b1, 1'b1, bsv_pkg::ST_SYNTAX,   bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_D,     1'b1, 1'b1, bsv_pkg::ST_TRUNC,    bsv_pkg::EV_DICT,    63'd0},
    '{bsv_pkg::CH_E,     1'b1, 1'b1, bsv_pkg::ST_SYNTAX,   bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_D,     1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{8'h33,             1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_COLON, 1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_STR_HDR, 63'd3},
    '{8'h00,             1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{8'hFF,             1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{8'h7A,             1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_STR_END, 63'd0},
    '{bsv_pkg::CH_L,     1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_LIST,    63'd0},
    '{bsv_pkg::CH_I,     1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_NINE,  1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_E,     1'b0, 1'b1, bsv_pkg::ST_RUN,      bsv_pkg::EV_INT_END, 63'd9},
    '{bsv_pkg::CH_E,     1'b0, 1'b0, bsv_pkg::ST_RUN,      bsv_pkg::EV_NONE,    63'd0},
    '{bsv_pkg::CH_E,     1'b1, 1'b1, bsv_pkg::ST_COMPLETE, bsv_pkg::EV_CLOSE,   63'd0}
  };

  // one beat: hold until accepted, then record what it should produce
  task automatic send_beat(logic [7:0] b, logic last, bit typed, dir_row_t row);
    parse_res_t r;
    in_valid = 1'b1;
    in_data_byte = b;
    in_last_byte = last;
    do @(posedge clk); while (in_stall);
    r = parse_byte(b, last);
    if (typed) begin
      r.st = row.st;
      r.ev = row.ev;
      r.tok = row.tok;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(bit v);
    drain();
    cfg_we = 1'b1;
    cfg_require_dictionary = v;
    @(negedge clk);
    cfg_we = 1'b0;
    req_dict = v;
  endtask

  task automatic push_decimal(logic [63:0] v);
    string s;
    s = $sformatf("%0d", v);
    for (int k = 0; k < s.len(); k++) buf_bytes.push_back(s[k]);
  endtask

  task automatic gen_string();
    int n;
    if ($urandom_range(0, 39) == 0) begin
      // length too large for 63 bits
      repeat (20) buf_bytes.push_back(bsv_pkg::CH_NINE);
      buf_bytes.push_back(bsv_pkg::CH_COLON);
    end else begin
      n = $urandom_range(0, 6);
      push_decimal(64'(n));
      buf_bytes.push_back(bsv_pkg::CH_COLON);
      repeat (n) buf_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_value(int lvl, bit force_dict);
    int kind;
    int n;
    kind = force_dict ? 3 : $urandom_range(0, (lvl >= 4) ? 1 : 3);
    case (kind)
      0: gen_string();
      1: begin
        buf_bytes.push_back(bsv_pkg::CH_I);
        if ($urandom_range(0, 19) == 0) begin
          n = $urandom_range(19, 20);
          repeat (n) buf_bytes.push_back(8'(bsv_pkg::CH_ZERO + $urandom_range(0, 9)));
        end else begin
          n = $urandom_range(0, 4);
          repeat (n) buf_bytes.push_back(8'(bsv_pkg::CH_ZERO + $urandom_range(0, 9)));
        end
        buf_bytes.push_back(bsv_pkg::CH_E);
      end
      2: begin
        buf_bytes.push_back(bsv_pkg::CH_L);
        n = $urandom_range(0, 3);
        repeat (n) gen_value(lvl + 1, 1'b0);
        buf_bytes.push_back(bsv_pkg::CH_E);
      end
      default: begin
        buf_bytes.push_back(bsv_pkg::CH_D);
        n = $urandom_range(0, 3);
        repeat (n) begin
          gen_string();
          gen_value(lvl + 1, 1'b0);
        end
        buf_bytes.push_back(bsv_pkg::CH_E);
      end
    endcase
  endtask

  task automatic random_buffers(int n_items);
    int sent;
    int r;
    int k;
    int burst;
    dir_row_t none;
    none = '{8'h00, 1'b0, 1'b0, bsv_pkg::ST_RUN, bsv_pkg::EV_NONE, 63'd0};
    sent = 0;
    burst = 0;
    while (sent < n_items) begin
      buf_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // one container more than the stack holds
        buf_bytes.push_back(bsv_pkg::CH_D);
        push_decimal(64'd1);
        buf_bytes.push_back(bsv_pkg::CH_COLON);
        buf_bytes.push_back(8'h61);
        repeat (DEPTH_LIMIT) buf_bytes.push_back(bsv_pkg::CH_L);
      end else begin
        gen_value(0, req_dict || ($urandom_range(0, 2) == 0));
        r = $urandom_range(0, 99);
        if (r < 12) begin
          buf_bytes[$urandom_range(0, buf_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 20) begin
          k = $urandom_range(1, buf_bytes.size());
          while (buf_bytes.size() > k) void'(buf_bytes.pop_back());
        end else if (r < 27) begin
          repeat ($urandom_range(1, 3)) buf_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (int j = 0; j < buf_bytes.size(); j++) begin
        if (burst == 0) begin
          in_valid = 1'b0;
          repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
          burst = $urandom_range(1, 24);
        end
        burst--;
        send_beat(buf_bytes[j], j == buf_bytes.size() - 1, 1'b0, none);
        sent++;
      end
    end
    in_valid = 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off so the block backs up
  initial begin
    int cyc;
    int run;
    int style;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      style = $urandom_range(0, 3);
      run = $urandom_range(5, 60);
      repeat (run) begin
        @(negedge clk);
        cyc++;
        if (cyc == 400) begin
          out_stall = 1'b1;
          repeat (400) @(negedge clk);
        end
        case (style)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 1) == 1);
          2: out_stall = (cyc % 3 == 0);
          default: out_stall = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    parse_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at offset %0d", out_byte_offset);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.st || out_event_res !== e.ev || out_token_value !== e.tok ||
            out_nest_depth !== e.dep || out_byte_offset !== e.off ||
            out_buffer_end !== e.bend) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch off %0d: exp st %0d ev %0d tok %0d dep %0d end %0d",
                      " / got st %0d ev %0d tok %0d dep %0d off %0d end %0d"},
                     e.off, e.st, e.ev, e.tok, e.dep, e.bend, out_status, out_event_res,
                     out_token_value, out_nest_depth, out_byte_offset, out_buffer_end);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** bencode_stream_validator: FAILED **");
      $finish;
    end
  end

  initial begin
    req_dict = 1'b1;
    clear_parse();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int i = 0; i < 25; i++)
      send_beat(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i]);
    in_valid = 1'b0;
    write_cfg(1'b0);
    random_buffers(300);
    write_cfg(1'b1);
    random_buffers(300);
    write_cfg(1'b0);
    random_buffers(300);
    write_cfg(1'b1);
    random_buffers(300);
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** bencode_stream_validator: PASSED **");
    else
      $display("** bencode_stream_validator: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/bsv_pkg.sv
rtl/bsv_front.sv
rtl/bsv_back.sv
rtl/bencode_stream_validator.sv
rtl/bsv_checker.sv
verif/tb.sv
